// File: rtl/core/gwm_pkg.sv
// shared types and constants for the glob wildcard matcher
`default_nettype none

package gwm_pkg;

   localparam int unsigned MAX_PATTERN_DEF = 32;

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] ANY_BYTE  = 8'h3F;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic clear;
      logic append;
      logic text;
      logic finish;
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       is_star;
      logic       is_any;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/core/glob_wildcard_matcher.sv
// top level of the glob wildcard matcher
//
// Request channel (req_valid / req_stall) carries one command per transaction:
// clear pattern, append pattern byte, text byte or end of text. A pattern of
// up to MAX_PATTERN bytes is loaded with appends ('*' any run, '?' any byte);
// extra bytes are dropped and flagged. Text bytes then stream in, and end of
// text returns one response transaction (rsp_valid / rsp_stall) with
// rsp_matched and rsp_pattern_overflow, after which the text state restarts.
// Any append also restarts the text state.
// Throughput: one transaction per cycle while req_stall is low; each text byte
// updates all pattern positions at once in a single bit-parallel step of the
// position vector. An end-of-text transaction waits in the four-entry queue,
// then is popped into the result register that drives rsp_valid; earlier
// queued items and a stalled response can hold it in the queue.
// Reset empties the pattern, clears the overflow flag, empties the queue and
// drops any pending response. While rsp_stall is high the response holds,
// later non-ending commands keep executing until another end of text reaches
// the queue head, and once the queue fills req_stall is raised.
`default_nettype none

module glob_wildcard_matcher #(
   parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_byte_value,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   logic              queue_full;
   logic              push;
   logic              pop;
   logic              head_valid;
   gwm_pkg::item_type push_item;
   gwm_pkg::item_type head_item;

   gwm_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_byte_value (req_byte_value),
      .queue_full     (queue_full),
      .push           (push),
      .push_item      (push_item)
   );

   gwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   gwm_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_item            (head_item),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

endmodule

`default_nettype wire

// File: rtl/core/gwm_front.sv
// front end: accepts request transactions and classifies them for the queue
`default_nettype none

module gwm_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_command,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic              queue_full,
   output logic                   push,
   output gwm_pkg::item_type      push_item
);

   gwm_pkg::op_type op;

   always_comb begin
      op = '0;
      case (gwm_pkg::cmd_type'(req_command))
         gwm_pkg::CMD_CLEAR:  op.clear  = 1'b1;
         gwm_pkg::CMD_APPEND: op.append = 1'b1;
         gwm_pkg::CMD_TEXT:   op.text   = 1'b1;
         gwm_pkg::CMD_END:    op.finish = 1'b1;
         default:             op        = '0;
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   // star and any-byte flags are worked out here so the back end only stores them
   always_comb begin
      push_item.op      = op;
      push_item.data    = req_byte_value;
      push_item.is_star = (req_byte_value == gwm_pkg::STAR_BYTE);
      push_item.is_any  = (req_byte_value == gwm_pkg::ANY_BYTE);
   end

endmodule

`default_nettype wire

// File: rtl/core/gwm_queue.sv
// short fifo between the front end and the back end
`default_nettype none

module gwm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  gwm_pkg::item_type      push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output gwm_pkg::item_type      head_item
);

   gwm_pkg::item_type                entries_ff [gwm_pkg::QUEUE_DEPTH];
   logic [gwm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [gwm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [gwm_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full       = (count_ff == gwm_pkg::QCNT_W'(gwm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gwm_back.sv
// back end: pattern store, reachable-position vector and result register
`default_nettype none

module gwm_back #(
   parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  gwm_pkg::item_type      head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_matched,
   output logic                   rsp_pattern_overflow
);

   localparam int unsigned RW    = MAX_PATTERN + 1;
   localparam int unsigned LEN_W = $clog2(RW);
   localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int unsigned LVL   = $clog2(RW);

   logic [7:0]             store_ff [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] star_ff;
   logic [MAX_PATTERN-1:0] any_ff;
   logic [MAX_PATTERN-1:0] len_mask_ff, len_mask_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic [RW-1:0]          reach_ff, reach_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_matched_ff, rsp_matched_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic [MAX_PATTERN-1:0] hit;
   logic [MAX_PATTERN-1:0] star_eff;
   logic [RW-1:0]          g_lvl [LVL+1];
   logic [RW-1:0]          p_lvl [LVL+1];
   logic [RW-1:0]          closed;
   logic [RW-1:0]          advanced;
   logic                   out_free;
   logic                   pat_full;
   logic                   finish_pop;
   logic [IDX_W-1:0]       wr_idx;

   assign star_eff = star_ff & len_mask_ff;
   assign pat_full = (len_ff == LEN_W'(MAX_PATTERN));
   assign wr_idx   = len_ff[IDX_W-1:0];

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         hit[i] = len_mask_ff[i] & ~star_ff[i] &
                  (any_ff[i] | (store_ff[i] == head_item.data));
      end
   end

   // closure over star runs as a parallel prefix, like a carry chain
   always_comb begin
      g_lvl[0] = reach_ff;
      p_lvl[0] = {star_eff, 1'b0};
      for (int k = 0; k < LVL; k++) begin
         g_lvl[k+1] = g_lvl[k] | (p_lvl[k] & (g_lvl[k] << (1 << k)));
         p_lvl[k+1] = p_lvl[k] & (p_lvl[k] << (1 << k));
      end
      closed = g_lvl[LVL];
   end

   // a star keeps its position, a matching byte moves one position on
   assign advanced = {closed[MAX_PATTERN-1:0] & hit, 1'b0} |
                     {1'b0, closed[MAX_PATTERN-1:0] & star_eff};

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign pop        = head_valid & (~head_item.op.finish | out_free);
   assign finish_pop = pop & head_item.op.finish;

   always_comb begin
      len_mask_in    = len_mask_ff;
      len_in         = len_ff;
      ovf_in         = ovf_ff;
      reach_in       = reach_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      if (pop) begin
         if (head_item.op.clear) begin
            len_mask_in = '0;
            len_in      = '0;
            ovf_in      = 1'b0;
            reach_in    = RW'(1);
         end else if (head_item.op.append) begin
            if (pat_full) begin
               ovf_in = 1'b1;
            end else begin
               len_mask_in[wr_idx] = 1'b1;
               len_in              = len_ff + 1'b1;
            end
            reach_in = RW'(1);
         end else if (head_item.op.text) begin
            reach_in = advanced;
         end else begin
            rsp_valid_in   = 1'b1;
            rsp_matched_in = closed[len_ff];
            rsp_ovf_in     = ovf_ff;
            reach_in       = RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_mask_ff  <= '0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         reach_ff     <= RW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_mask_ff  <= len_mask_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         reach_ff     <= reach_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      if (pop && head_item.op.append && !pat_full) begin
         store_ff[wr_idx] <= head_item.data;
         star_ff[wr_idx]  <= head_item.is_star;
         any_ff[wr_idx]   <= head_item.is_any;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   a_reach_restart: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_item.op.text) |=> (reach_ff == RW'(1)))
      else $error("reach vector not restarted");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LEN_W'(MAX_PATTERN)))
      else $error("overflow set with pattern not full");

   a_len_mask: assert property (@(posedge clock) disable iff (reset)
      ($countones(len_mask_ff) == int'(len_ff)) &&
      ((len_mask_ff & (len_mask_ff + 1'b1)) == '0))
      else $error("length mask out of step with length");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish_pop))
      else $error("response without end of text");

endmodule

`default_nettype wire

// File: bench/tb_glob_wildcard_matcher.sv
// self-checking testbench for the glob wildcard matcher
`timescale 1ns / 100ps

class match_scoreboard;
   localparam int unsigned PAT_CAP = gwm_pkg::MAX_PATTERN_DEF;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic [7:0]     pattern_bytes [PAT_CAP];
   int unsigned    pattern_len;
   logic [PAT_CAP:0] reach;
   logic           overflow_seen;
   verdict_type    expected_verdicts [$];
   int unsigned    mismatches;

   function new();
      foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
      pattern_len   = 0;
      reach         = 1;
      overflow_seen = 1'b0;
      mismatches    = 0;
   endfunction

   // positions behind a reachable star are reachable too
   function logic [PAT_CAP:0] close_stars(logic [PAT_CAP:0] v);
      int unsigned i;
      for (i = 0; i < pattern_len; i++) begin
         if (v[i] && pattern_bytes[i] == gwm_pkg::STAR_BYTE) v[i + 1] = 1'b1;
      end
      return v;
   endfunction

   function logic [PAT_CAP:0] step_text(logic [PAT_CAP:0] v, logic [7:0] c);
      logic [PAT_CAP:0] nv;
      int unsigned i;
      nv = '0;
      v  = close_stars(v);
      for (i = 0; i < pattern_len; i++) begin
         if (v[i]) begin
            if (pattern_bytes[i] == gwm_pkg::STAR_BYTE) begin
               nv[i] = 1'b1;
            end else if (pattern_bytes[i] == gwm_pkg::ANY_BYTE || pattern_bytes[i] == c) begin
               nv[i + 1] = 1'b1;
            end
         end
      end
      return nv;
   endfunction

   function void note_request(logic [1:0] c, logic [7:0] b);
      logic [PAT_CAP:0] v;
      verdict_type vd;
      case (gwm_pkg::cmd_type'(c))
         gwm_pkg::CMD_CLEAR: begin
            pattern_len   = 0;
            overflow_seen = 1'b0;
            reach         = 1;
         end
         gwm_pkg::CMD_APPEND: begin
            if (pattern_len < PAT_CAP) begin
               pattern_bytes[pattern_len] = b;
               pattern_len++;
            end else begin
               overflow_seen = 1'b1;
            end
            reach = 1;
         end
         gwm_pkg::CMD_TEXT: begin
            reach = step_text(reach, b);
         end
         default: begin
            v           = close_stars(reach);
            vd.matched  = v[pattern_len];
            vd.overflow = overflow_seen;
            expected_verdicts = {expected_verdicts, vd};
            reach = 1;
         end
      endcase
   endfunction

   function void check_response(logic m, logic o);
      verdict_type vd;
      if (expected_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: matched=%0d overflow=%0d", m, o);
         return;
      end
      vd = expected_verdicts.pop_front();
      if (m !== vd.matched || o !== vd.overflow) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: matched exp %0d got %0d, overflow exp %0d got %0d",
                     vd.matched, m, vd.overflow, o);
      end
   endfunction

   function int unsigned pending();
      return expected_verdicts.size();
   endfunction
endclass

module tb_glob_wildcard_matcher;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [1:0] req_command    = gwm_pkg::CMD_CLEAR;
   logic [7:0] req_byte_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   match_scoreboard sb = new();
   int unsigned     item_count = 0;
   bit              quiet      = 1'b0;

   glob_wildcard_matcher dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_byte_value       (req_byte_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_glob_wildcard_matcher: FAIL");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= !quiet && ($urandom_range(99) < 25);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_matched, rsp_pattern_overflow);
         if (req_valid && !req_stall) sb.note_request(req_command, req_byte_value);
      end
   end

   // entered and left at a falling edge
   task automatic send_item(input gwm_pkg::cmd_type c, input logic [7:0] b);
      while (!quiet && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= c;
      req_byte_value <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      item_count++;
   endtask

   function automatic logic [7:0] pick_byte(bit for_pattern);
      int unsigned r;
      r = $urandom_range(9);
      if (for_pattern && r < 2) return gwm_pkg::STAR_BYTE;
      if (for_pattern && r < 4) return gwm_pkg::ANY_BYTE;
      if (r < 8) return 8'h61 + 8'($urandom_range(for_pattern ? 1 : 2));
      return 8'($urandom);
   endfunction

   // one pattern followed by a few texts, mostly built to fit the pattern
   task automatic random_round();
      logic [7:0] pat [$];
      logic [7:0] txt [$];
      int unsigned plen;
      int unsigned k;
      logic [7:0] b;
      plen = ($urandom_range(14) == 0) ? $urandom_range(40, 30) : $urandom_range(8);
      send_item(gwm_pkg::CMD_CLEAR, 8'($urandom));
      for (k = 0; k < plen; k++) begin
         b = pick_byte(1'b1);
         if (pat.size() < gwm_pkg::MAX_PATTERN_DEF) pat = {pat, b};
         send_item(gwm_pkg::CMD_APPEND, b);
      end
      repeat ($urandom_range(4, 1)) begin
         txt = {};
         if ($urandom_range(3) != 0) begin
            foreach (pat[j]) begin
               if (pat[j] == gwm_pkg::STAR_BYTE) begin
                  repeat ($urandom_range(3)) txt = {txt, pick_byte(1'b0)};
               end else if (pat[j] == gwm_pkg::ANY_BYTE) begin
                  txt = {txt, pick_byte(1'b0)};
               end else begin
                  txt = {txt, pat[j]};
               end
            end
            if ($urandom_range(4) == 0 && txt.size() > 0)
               txt[$urandom_range(txt.size() - 1)] = pick_byte(1'b0);
         end else begin
            repeat ($urandom_range(10)) txt = {txt, pick_byte(1'b0)};
         end
         foreach (txt[j]) send_item(gwm_pkg::CMD_TEXT, txt[j]);
         if ($urandom_range(9) == 0)
            send_item(gwm_pkg::cmd_type'($urandom_range(3)), 8'($urandom));
         send_item(gwm_pkg::CMD_END, 8'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pattern against empty and non-empty text
      send_item(gwm_pkg::CMD_END, 8'h00);
      send_item(gwm_pkg::CMD_TEXT, 8'h00);
      send_item(gwm_pkg::CMD_END, 8'hFF);
      // lone star: empty text, then any text
      send_item(gwm_pkg::CMD_APPEND, gwm_pkg::STAR_BYTE);
      send_item(gwm_pkg::CMD_END, 8'h00);
      send_item(gwm_pkg::CMD_TEXT, 8'hFF);
      send_item(gwm_pkg::CMD_TEXT, 8'h00);
      send_item(gwm_pkg::CMD_END, 8'h00);
      // append in the middle of a text throws that text away
      send_item(gwm_pkg::CMD_APPEND, gwm_pkg::ANY_BYTE);
      send_item(gwm_pkg::CMD_TEXT, 8'h61);
      send_item(gwm_pkg::CMD_APPEND, 8'h62);
      send_item(gwm_pkg::CMD_TEXT, 8'h78);
      send_item(gwm_pkg::CMD_TEXT, 8'h62);
      send_item(gwm_pkg::CMD_END, 8'h00);
      send_item(gwm_pkg::CMD_TEXT, 8'h62);
      send_item(gwm_pkg::CMD_END, 8'h00);
      // zero byte only matches itself
      send_item(gwm_pkg::CMD_CLEAR, 8'hFF);
      send_item(gwm_pkg::CMD_APPEND, 8'h00);
      send_item(gwm_pkg::CMD_TEXT, 8'h00);
      send_item(gwm_pkg::CMD_END, 8'h00);
      send_item(gwm_pkg::CMD_TEXT, 8'hFF);
      send_item(gwm_pkg::CMD_END, 8'hFF);

      while (item_count < 1400) begin
         quiet = (item_count >= 500 && item_count < 800);
         random_round();
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_glob_wildcard_matcher: PASS");
      end else begin
         $display("tb_glob_wildcard_matcher: FAIL");
      end
      $finish;
   end
endmodule
